### sv/windowed_trimmed_variance_defines.svh
// Assertion macros shared by the windowed trimmed variance modules.
`ifndef WINDOWED_TRIMMED_VARIANCE_DEFINES_SVH
`define WINDOWED_TRIMMED_VARIANCE_DEFINES_SVH

// Checks a property on every rising clock edge outside of reset.
`define WTV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("windowed_trimmed_variance assertion failed");

// Checks that a condition never holds outside of reset.
`define WTV_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("windowed_trimmed_variance forbidden condition seen");

`endif

### sv/wtv_pkg.sv
// Shared types and constants of the windowed trimmed variance block.
package wtv_pkg;

  localparam int DEFAULT_WINDOW_DEPTH = 64;
  localparam int SIZE_W = 7;
  localparam int SAMPLE_W = 32;
  localparam int TRIM_W = 6;
  localparam int VAR_W = 64;
  localparam int STD_W = 32;
  localparam int USED_W = 7;
  localparam int ACC_W = 128;
  localparam int PROD_W = 64;
  localparam int DIV_CNT_W = 7;
  localparam int SQRT_CNT_W = 5;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_PUSH,
    OP_CLEAR,
    OP_QSETUP,
    OP_RANK_START,
    OP_RANK_STEP,
    OP_RANK_END,
    OP_VAR_START,
    OP_VAR_MUL,
    OP_VAR_SUB,
    OP_SQ_A,
    OP_SQ_B,
    OP_SQ_C,
    OP_SQ_D,
    OP_VAR_NEXT,
    OP_N2,
    OP_N3,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_SQRT_START,
    OP_SQRT_STEP,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    logic count_zero;
    logic keep_i;
    logic inner_done;
    logic i_last;
    logic div_last;
    logic sqrt_last;
    logic out_busy;
  } dp_status_t;

endpackage

### sv/wtv_if.sv
// Input and result channel interfaces of the windowed trimmed variance block.
interface wtv_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    command;
  logic signed [wtv_pkg::SAMPLE_W-1:0] sample;
  logic [wtv_pkg::TRIM_W-1:0]    trim_count;

  modport source (output valid, command, sample, trim_count, input ready);
  modport sink (input valid, command, sample, trim_count, output ready);
endinterface

interface wtv_out_if;
  logic                        valid;
  logic                        ready;
  logic [wtv_pkg::VAR_W-1:0]   variance;
  logic [wtv_pkg::STD_W-1:0]   std_deviation;
  logic [wtv_pkg::USED_W-1:0]  used_count;
  logic                        window_empty;

  modport source (output valid, variance, std_deviation, used_count, window_empty,
                  input ready);
  modport sink (input valid, variance, std_deviation, used_count, window_empty,
                output ready);
endinterface

### sv/wtv_datapath.sv
// Datapath: sample memory, rank counting, sums, squaring, divider and square root.
`include "windowed_trimmed_variance_defines.svh"

module wtv_datapath #(
  parameter int WINDOW_DEPTH = wtv_pkg::DEFAULT_WINDOW_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  wtv_pkg::dp_op_e                     op_i,
  output wtv_pkg::dp_status_t                 status_o,
  input  logic                                cfg_we_i,
  input  logic [wtv_pkg::SIZE_W-1:0]          cfg_wdata_i,
  input  logic signed [wtv_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [wtv_pkg::TRIM_W-1:0]          trim_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [wtv_pkg::VAR_W-1:0]           variance_o,
  output logic [wtv_pkg::STD_W-1:0]           std_o,
  output logic [wtv_pkg::USED_W-1:0]          used_o,
  output logic                                empty_o
);

  localparam int IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int CMP_W = ((CW > wtv_pkg::SIZE_W) ? CW : wtv_pkg::SIZE_W) + 1;
  localparam int DW = wtv_pkg::SAMPLE_W + CW + 1;
  localparam int HW = DW - 32;
  localparam int N3_W = 3 * CW;
  localparam int REM_W = N3_W + 1;
  localparam int SW = wtv_pkg::SAMPLE_W;

  logic signed [SW-1:0]   mem_q [WINDOW_DEPTH];
  logic signed [SW-1:0]   rda_q, rdb_q;

  logic [wtv_pkg::SIZE_W-1:0] size_q;
  logic [IW-1:0]          wp_q;
  logic                   full_q;

  logic [CW-1:0]          count_q, trim_q, hi_lim_q, n_q, rank_q, j_q;
  logic [IW-1:0]          i_q, jd_q;
  logic                   pend_q, empty_q;
  logic [WINDOW_DEPTH-1:0] keep_q;
  logic signed [DW-1:0]   sum_q, prod_q;
  logic [DW-1:0]          m_q;
  logic [wtv_pkg::PROD_W-1:0] p_q;
  logic [6:0]             sh_q;
  logic [wtv_pkg::ACC_W-1:0] acc_q;
  logic [2*CW-1:0]        nsq_q;
  logic [N3_W-1:0]        n3_q;
  logic [REM_W-1:0]       rem_q;
  logic [wtv_pkg::DIV_CNT_W-1:0] div_cnt_q;
  logic [wtv_pkg::VAR_W-1:0] var_q, v_q, res_q, bit_q;
  logic [wtv_pkg::SQRT_CNT_W-1:0] sqrt_cnt_q;

  logic                   out_valid_q, out_empty_q;
  logic [wtv_pkg::VAR_W-1:0]  out_var_q;
  logic [wtv_pkg::STD_W-1:0]  out_std_q;
  logic [wtv_pkg::USED_W-1:0] out_used_q;

  logic [CW-1:0]          count_now, trim_eff;
  logic [CMP_W-1:0]       wp_inc;
  logic                   push_wrap;
  logic [IW-1:0]          push_addr;
  logic                   size_ok;
  logic                   rank_lt;
  logic                   keep_now;
  logic [31:0]            a0;
  logic [HW-1:0]          a1;
  logic signed [DW-1:0]   diff;
  logic [REM_W-1:0]       rem_sh;
  logic                   rem_ge;
  logic [wtv_pkg::VAR_W-1:0] var_sat, sq_try;

  always_comb begin
    count_now = full_q ? CW'(size_q) : CW'(wp_q);
    if (CMP_W'({trim_i, 1'b0}) >= CMP_W'(count_now)) begin
      trim_eff = '0;
    end else begin
      trim_eff = CW'(trim_i);
    end
    push_addr = (CMP_W'(wp_q) >= CMP_W'(size_q)) ? '0 : wp_q;
    wp_inc = CMP_W'(push_addr) + CMP_W'(1);
    push_wrap = wp_inc >= CMP_W'(size_q);
    size_ok = (cfg_wdata_i != '0) && (int'(cfg_wdata_i) <= WINDOW_DEPTH);
    rank_lt = (rdb_q < rda_q) || ((rdb_q == rda_q) && (jd_q < i_q));
    keep_now = (rank_q >= trim_q) && (rank_q < hi_lim_q);
    a0 = m_q[31:0];
    a1 = m_q[DW-1:32];
    diff = prod_q - sum_q;
    rem_sh = {rem_q[REM_W-2:0], acc_q[wtv_pkg::ACC_W-1]};
    rem_ge = rem_sh >= REM_W'(n3_q);
    var_sat = (acc_q[wtv_pkg::ACC_W-1:wtv_pkg::VAR_W] != '0) ? '1
                                                             : acc_q[wtv_pkg::VAR_W-1:0];
    sq_try = res_q + bit_q;
  end

  always_ff @(posedge clk_i) begin
    if (op_i == wtv_pkg::OP_PUSH) begin
      mem_q[push_addr] <= sample_i;
    end
    rda_q <= mem_q[i_q];
    rdb_q <= mem_q[j_q[IW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= wtv_pkg::SIZE_W'(1);
      wp_q <= '0;
      full_q <= 1'b0;
      pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && size_ok) begin
        size_q <= cfg_wdata_i;
        wp_q <= '0;
        full_q <= 1'b0;
      end else if (op_i == wtv_pkg::OP_PUSH) begin
        if (push_wrap) begin
          wp_q <= '0;
          full_q <= 1'b1;
        end else begin
          wp_q <= IW'(wp_inc);
        end
      end else if (op_i == wtv_pkg::OP_CLEAR) begin
        wp_q <= '0;
        full_q <= 1'b0;
      end
      if (op_i == wtv_pkg::OP_RANK_STEP) begin
        pend_q <= CMP_W'(j_q) < CMP_W'(count_q);
      end else begin
        pend_q <= 1'b0;
      end
      if (op_i == wtv_pkg::OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      wtv_pkg::OP_QSETUP: begin
        count_q <= count_now;
        trim_q <= trim_eff;
        hi_lim_q <= count_now - trim_eff;
        n_q <= count_now - {trim_eff[CW-2:0], 1'b0};
        empty_q <= count_now == '0;
        i_q <= '0;
        sum_q <= '0;
      end
      wtv_pkg::OP_RANK_START: begin
        j_q <= '0;
        rank_q <= '0;
      end
      wtv_pkg::OP_RANK_STEP: begin
        if (CMP_W'(j_q) < CMP_W'(count_q)) begin
          jd_q <= j_q[IW-1:0];
          j_q <= j_q + CW'(1);
        end
        if (pend_q && rank_lt) begin
          rank_q <= rank_q + CW'(1);
        end
      end
      wtv_pkg::OP_RANK_END: begin
        keep_q[i_q] <= keep_now;
        if (keep_now) begin
          sum_q <= sum_q + DW'(rda_q);
        end
        i_q <= i_q + IW'(1);
      end
      wtv_pkg::OP_VAR_START: begin
        i_q <= '0;
        acc_q <= '0;
      end
      wtv_pkg::OP_VAR_MUL: begin
        prod_q <= DW'($signed({1'b0, n_q}) * rda_q);
      end
      wtv_pkg::OP_VAR_SUB: begin
        m_q <= diff[DW-1] ? DW'(-diff) : DW'(diff);
      end
      wtv_pkg::OP_SQ_A: begin
        p_q <= {32'd0, a0} * {32'd0, a0};
        sh_q <= 7'd0;
      end
      wtv_pkg::OP_SQ_B: begin
        acc_q <= acc_q + (wtv_pkg::ACC_W'(p_q) << sh_q);
        p_q <= wtv_pkg::PROD_W'(a0 * a1);
        sh_q <= 7'd33;
      end
      wtv_pkg::OP_SQ_C: begin
        acc_q <= acc_q + (wtv_pkg::ACC_W'(p_q) << sh_q);
        p_q <= wtv_pkg::PROD_W'(a1 * a1);
        sh_q <= 7'd64;
      end
      wtv_pkg::OP_SQ_D: begin
        acc_q <= acc_q + (wtv_pkg::ACC_W'(p_q) << sh_q);
      end
      wtv_pkg::OP_VAR_NEXT: begin
        i_q <= i_q + IW'(1);
      end
      wtv_pkg::OP_N2: begin
        nsq_q <= n_q * n_q;
      end
      wtv_pkg::OP_N3: begin
        n3_q <= nsq_q * n_q;
      end
      wtv_pkg::OP_DIV_START: begin
        rem_q <= '0;
        div_cnt_q <= '0;
      end
      wtv_pkg::OP_DIV_STEP: begin
        rem_q <= rem_ge ? rem_sh - REM_W'(n3_q) : rem_sh;
        acc_q <= {acc_q[wtv_pkg::ACC_W-2:0], rem_ge};
        div_cnt_q <= div_cnt_q + wtv_pkg::DIV_CNT_W'(1);
      end
      wtv_pkg::OP_SQRT_START: begin
        var_q <= var_sat;
        v_q <= var_sat;
        res_q <= '0;
        bit_q <= 64'h4000_0000_0000_0000;
        sqrt_cnt_q <= '0;
      end
      wtv_pkg::OP_SQRT_STEP: begin
        if (v_q >= sq_try) begin
          v_q <= v_q - sq_try;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
        sqrt_cnt_q <= sqrt_cnt_q + wtv_pkg::SQRT_CNT_W'(1);
      end
      wtv_pkg::OP_EMIT: begin
        out_empty_q <= empty_q;
        out_var_q <= empty_q ? '0 : var_q;
        out_std_q <= empty_q ? '0 : res_q[wtv_pkg::STD_W-1:0];
        out_used_q <= wtv_pkg::USED_W'(n_q);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    status_o.count_zero = count_q == '0;
    status_o.keep_i = keep_q[i_q];
    status_o.inner_done = (CMP_W'(j_q) >= CMP_W'(count_q)) && !pend_q;
    status_o.i_last = CMP_W'(i_q) == CMP_W'(count_q - CW'(1));
    status_o.div_last = div_cnt_q == '1;
    status_o.sqrt_last = sqrt_cnt_q == '1;
    status_o.out_busy = out_valid_q;
  end

  assign out_valid_o = out_valid_q;
  assign variance_o = out_var_q;
  assign std_o = out_std_q;
  assign used_o = out_used_q;
  assign empty_o = out_empty_q;

  `WTV_ASSERT(a_wp_in_window, CMP_W'(wp_q) < CMP_W'(size_q))
  `WTV_ASSERT(a_out_from_emit, $rose(out_valid_q) |-> $past(op_i == wtv_pkg::OP_EMIT))
  `WTV_ASSERT_NEVER(a_emit_over_busy, (op_i == wtv_pkg::OP_EMIT) && out_valid_q)

endmodule

### sv/wtv_ctrl.sv
// Controller state machine that sequences queries through the datapath.
`include "windowed_trimmed_variance_defines.svh"

module wtv_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_command_i,
  output logic                in_ready_o,
  input  wtv_pkg::dp_status_t status_i,
  output wtv_pkg::dp_op_e     op_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_QCHECK, S_RANK_START, S_RANK, S_RANK_END, S_VAR_START, S_VAR_RD,
    S_VAR_MUL, S_VAR_SUB, S_SQ_A, S_SQ_B, S_SQ_C, S_SQ_D, S_VAR_NEXT, S_N2, S_N3,
    S_DIV_START, S_DIV, S_SQRT_START, S_SQRT, S_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    op_o = wtv_pkg::OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          priority if (in_command_i == wtv_pkg::CMD_PUSH) begin
            op_o = wtv_pkg::OP_PUSH;
          end else if (in_command_i == wtv_pkg::CMD_CLEAR) begin
            op_o = wtv_pkg::OP_CLEAR;
          end else if (in_command_i == wtv_pkg::CMD_QUERY) begin
            op_o = wtv_pkg::OP_QSETUP;
            state_d = S_QCHECK;
          end else begin
            op_o = wtv_pkg::OP_NONE;
          end
        end
      end
      S_QCHECK: state_d = status_i.count_zero ? S_EMIT : S_RANK_START;
      S_RANK_START: begin
        op_o = wtv_pkg::OP_RANK_START;
        state_d = S_RANK;
      end
      S_RANK: begin
        op_o = wtv_pkg::OP_RANK_STEP;
        if (status_i.inner_done) begin
          state_d = S_RANK_END;
        end
      end
      S_RANK_END: begin
        op_o = wtv_pkg::OP_RANK_END;
        state_d = status_i.i_last ? S_VAR_START : S_RANK_START;
      end
      S_VAR_START: begin
        op_o = wtv_pkg::OP_VAR_START;
        state_d = S_VAR_RD;
      end
      S_VAR_RD: state_d = S_VAR_MUL;
      S_VAR_MUL: begin
        if (status_i.keep_i) begin
          op_o = wtv_pkg::OP_VAR_MUL;
          state_d = S_VAR_SUB;
        end else begin
          state_d = S_VAR_NEXT;
        end
      end
      S_VAR_SUB: begin
        op_o = wtv_pkg::OP_VAR_SUB;
        state_d = S_SQ_A;
      end
      S_SQ_A: begin
        op_o = wtv_pkg::OP_SQ_A;
        state_d = S_SQ_B;
      end
      S_SQ_B: begin
        op_o = wtv_pkg::OP_SQ_B;
        state_d = S_SQ_C;
      end
      S_SQ_C: begin
        op_o = wtv_pkg::OP_SQ_C;
        state_d = S_SQ_D;
      end
      S_SQ_D: begin
        op_o = wtv_pkg::OP_SQ_D;
        state_d = S_VAR_NEXT;
      end
      S_VAR_NEXT: begin
        op_o = wtv_pkg::OP_VAR_NEXT;
        state_d = status_i.i_last ? S_N2 : S_VAR_RD;
      end
      S_N2: begin
        op_o = wtv_pkg::OP_N2;
        state_d = S_N3;
      end
      S_N3: begin
        op_o = wtv_pkg::OP_N3;
        state_d = S_DIV_START;
      end
      S_DIV_START: begin
        op_o = wtv_pkg::OP_DIV_START;
        state_d = S_DIV;
      end
      S_DIV: begin
        op_o = wtv_pkg::OP_DIV_STEP;
        if (status_i.div_last) begin
          state_d = S_SQRT_START;
        end
      end
      S_SQRT_START: begin
        op_o = wtv_pkg::OP_SQRT_START;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        op_o = wtv_pkg::OP_SQRT_STEP;
        if (status_i.sqrt_last) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!status_i.out_busy) begin
          op_o = wtv_pkg::OP_EMIT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

  `WTV_ASSERT(a_query_leaves_idle,
              (in_valid_i && in_ready_o && (in_command_i == wtv_pkg::CMD_QUERY))
              |=> (state_q == S_QCHECK))
  `WTV_ASSERT(a_div_to_sqrt, (state_q == S_DIV && status_i.div_last) |=> (state_q == S_SQRT_START))

endmodule

### sv/windowed_trimmed_variance.sv
// Top level of the windowed trimmed variance block.
// The block holds the last window_size signed Q16.16 samples. Push and clear beats are
// taken without leaving the idle state. A query ranks the held samples with a
// comparison loop over the sample memory, then forms the squared deviations of the
// kept samples, the cube of the count, the bit-serial divider and the bit-serial square
// root. The result sits in an output register, and new beats are taken while it waits.
// The sample memory needs no clearing pass.
`include "windowed_trimmed_variance_defines.svh"

module windowed_trimmed_variance #(
  parameter int WINDOW_DEPTH = wtv_pkg::DEFAULT_WINDOW_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [wtv_pkg::SIZE_W-1:0] cfg_wdata_i,
  wtv_in_if.sink                     req_i,
  wtv_out_if.source                  rsp_o
);

  wtv_pkg::dp_op_e     op;
  wtv_pkg::dp_status_t status;

  wtv_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (req_i.valid),
    .in_command_i (req_i.command),
    .in_ready_o   (req_i.ready),
    .status_i     (status),
    .op_o         (op)
  );

  wtv_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (req_i.sample),
    .trim_i      (req_i.trim_count),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .variance_o  (rsp_o.variance),
    .std_o       (rsp_o.std_deviation),
    .used_o      (rsp_o.used_count),
    .empty_o     (rsp_o.window_empty)
  );

  `WTV_ASSERT(a_ready_blocks_during_query, (!req_i.ready) |-> (op != wtv_pkg::OP_PUSH))

endmodule
